// ===== sv/trf_pkg.sv =====
// ----------------------------------------------------------------------------
// trf_pkg: shared definitions for the threshold region finder
// Field widths, configuration register decode and the region record type.
// ----------------------------------------------------------------------------
package trf_pkg;

    localparam int DATA_W          = 16;
    localparam int PAD_W           = 10;
    localparam int OUT_W           = 12;
    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;
    localparam int QUEUE_DEPTH     = 3;

    typedef enum logic {
        REG_THRESHOLD = 1'b0,
        REG_PAD       = 1'b1
    } t_reg_sel;

    typedef logic [OUT_W-1:0] t_out_idx;

    typedef struct packed {
        t_out_idx region_first;
        t_out_idx region_final;
        logic     final_region;
    } t_region;

endpackage

// ===== sv/trf_if.sv =====
// ----------------------------------------------------------------------------
// trf_if: request channels of the threshold region finder
// Sample channel into the block and region channel out of it.
// ----------------------------------------------------------------------------
interface trf_sample_if import trf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sample_value;
    logic                     end_of_waveform;

    modport source (output valid, output sample_value, output end_of_waveform, input ready);
    modport sink   (input valid, input sample_value, input end_of_waveform, output ready);
endinterface

interface trf_region_if import trf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] region_first;
    logic [OUT_W-1:0] region_final;
    logic             final_region;

    modport source (output valid, output region_first, output region_final,
                    output final_region, input ready);
    modport sink   (input valid, input region_first, input region_final,
                    input final_region, output ready);
endinterface

// ===== sv/threshold_region_finder.sv =====
// ----------------------------------------------------------------------------
// threshold_region_finder: threshold crossing region detector
// Opens a region on samples below the threshold, pads and merges regions,
// and reports each merged region with a flag on the last one of a waveform.
// ----------------------------------------------------------------------------
// The sample is held in the input register and its regions are written to the result queue,
// from which they are offered. Throughput: one sample per cycle; a sample that yields two
// regions is offered as two output requests, and the input stalls when the three-entry result
// queue cannot hold all regions of the held sample.
// Reset: synchronous, active low; clears configuration, region state and queue.
module threshold_region_finder import trf_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    trf_sample_if.sink            i_sample,
    trf_region_if.source          o_region,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int END_W = ((IDX_W > PAD_W) ? IDX_W : PAD_W) + 1;
    localparam int CMP_W = END_W + 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

    logic signed [DATA_W-1:0] r_threshold;
    logic [PAD_W-1:0]         r_pad;

    logic                     r_in_valid;
    logic signed [DATA_W-1:0] r_sample;
    logic                     r_eow;

    logic [IDX_W-1:0] r_idx,        n_idx;
    logic             r_inside,     n_inside;
    logic [IDX_W-1:0] r_open_start, n_open_start;
    logic             r_pv,         n_pv;
    logic [IDX_W-1:0] r_ps,         n_ps;
    logic [END_W-1:0] r_pe,         n_pe;

    t_region          r_q [QUEUE_DEPTH];
    t_region          n_q [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_count, n_count;

    logic             w_below;
    logic [END_W-1:0] w_idx_e;
    logic [END_W-1:0] w_pad_e;
    logic [END_W-1:0] w_sum;
    logic [IDX_W-1:0] w_open_calc;
    logic [END_W-1:0] w_close_end;
    logic             w_reg_valid;
    logic [IDX_W-1:0] w_reg_start;
    logic [END_W-1:0] w_reg_end;
    logic             w_merge;
    logic             w_emit0;
    logic             w_emit1;
    logic [END_W-1:0] w_clamp;
    t_region          w_res0;
    t_region          w_res1;
    logic [CNT_W-1:0] w_nres;
    logic             w_process;
    logic             w_pop;
    logic [CNT_W-1:0] w_base;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_pad       <= '0;
        end else if (w_cfg_wr) begin
            case (t_reg_sel'(paddr[APB_ADDR_W-1]))
                REG_THRESHOLD: r_threshold <= pwdata[DATA_W-1:0];
                REG_PAD:       r_pad       <= pwdata[PAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_sel'(paddr[APB_ADDR_W-1]))
            REG_THRESHOLD: prdata = {{(APB_DATA_W-DATA_W){r_threshold[DATA_W-1]}}, r_threshold};
            REG_PAD:       prdata = {{(APB_DATA_W-PAD_W){1'b0}}, r_pad};
            default:       prdata = '0;
        endcase
    end

    assign i_sample.ready = !r_in_valid || w_process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_sample <= i_sample.sample_value;
            r_eow    <= i_sample.end_of_waveform;
        end
    end

    assign w_below     = r_sample < r_threshold;
    assign w_idx_e     = END_W'(r_idx);
    assign w_pad_e     = END_W'(r_pad);
    assign w_sum       = w_idx_e + w_pad_e;
    assign w_open_calc = (w_idx_e >= w_pad_e) ? IDX_W'(w_idx_e - w_pad_e) : '0;
    assign w_close_end = (w_sum != '0) ? w_sum - END_W'(1) : '0;

    always_comb begin
        n_inside     = r_inside;
        n_open_start = r_open_start;
        w_reg_valid  = 1'b0;
        w_reg_start  = r_open_start;
        w_reg_end    = w_close_end;

        if (w_below && !r_inside) begin
            n_open_start = w_open_calc;
            n_inside     = 1'b1;
        end else if (!w_below && r_inside) begin
            n_inside    = 1'b0;
            w_reg_valid = 1'b1;
        end

        if (r_eow && n_inside) begin
            n_inside    = 1'b0;
            w_reg_valid = 1'b1;
            w_reg_start = n_open_start;
            w_reg_end   = w_idx_e;
        end

        n_pv    = r_pv;
        n_ps    = r_ps;
        n_pe    = r_pe;
        w_emit0 = 1'b0;
        w_res0  = '{region_first: OUT_W'(r_ps), region_final: OUT_W'(r_pe),
                    final_region: 1'b0};
        w_merge = r_pv && (CMP_W'(w_reg_start) <= CMP_W'(r_pe) + CMP_W'(r_pad));

        if (w_reg_valid) begin
            if (w_merge) begin
                if (w_reg_end > r_pe) begin
                    n_pe = w_reg_end;
                end
            end else begin
                w_emit0 = r_pv;
                n_pv    = 1'b1;
                n_ps    = w_reg_start;
                n_pe    = w_reg_end;
            end
        end

        w_emit1 = 1'b0;
        w_clamp = (n_pe > w_idx_e) ? w_idx_e : n_pe;
        w_res1  = '{region_first: OUT_W'(n_ps), region_final: OUT_W'(w_clamp),
                    final_region: 1'b1};

        if (r_eow) begin
            w_emit1 = n_pv;
            n_pv    = 1'b0;
            n_pe    = w_clamp;
            n_idx   = '0;
        end else begin
            n_idx = (r_idx < IDX_LAST) ? r_idx + IDX_W'(1) : r_idx;
        end

        w_nres = CNT_W'(w_emit0) + CNT_W'(w_emit1);
    end

    assign w_process = r_in_valid &&
                       ((CNT_W+1)'(r_count) + (CNT_W+1)'(w_nres) <= (CNT_W+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_inside     <= 1'b0;
            r_open_start <= '0;
            r_pv         <= 1'b0;
            r_ps         <= '0;
            r_pe         <= '0;
        end else if (w_process) begin
            r_idx        <= n_idx;
            r_inside     <= n_inside;
            r_open_start <= n_open_start;
            r_pv         <= n_pv;
            r_ps         <= n_ps;
            r_pe         <= n_pe;
        end
    end

    assign o_region.valid        = r_count != '0;
    assign o_region.region_first = r_q[0].region_first;
    assign o_region.region_final = r_q[0].region_final;
    assign o_region.final_region = r_q[0].final_region;
    assign w_pop                 = o_region.valid && o_region.ready;
    assign w_base                = r_count - CNT_W'(w_pop);

    always_comb begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            n_q[j] = r_q[j];
        end
        if (w_pop) begin
            for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                n_q[j] = r_q[j + 1];
            end
        end
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            if (w_process && (w_nres != '0) && (CNT_W'(j) == w_base)) begin
                n_q[j] = w_emit0 ? w_res0 : w_res1;
            end
            if (w_process && w_emit0 && w_emit1 && (CNT_W'(j) == w_base + CNT_W'(1))) begin
                n_q[j] = w_res1;
            end
        end
        n_count = w_base + (w_process ? w_nres : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            r_q[j] <= n_q[j];
        end
    end

endmodule

// ===== sv/trf_checker.sv =====
// ----------------------------------------------------------------------------
// trf_checker: port-level checks for the threshold region finder
// Watches the region channel and the configuration port over time.
// ----------------------------------------------------------------------------
module trf_checker import trf_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [OUT_W-1:0]      i_out_first,
    input logic [OUT_W-1:0]      i_out_last,
    input logic                  i_out_fin,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [APB_ADDR_W-1:0] paddr,
    input logic [APB_DATA_W-1:0] pwdata,
    input logic [APB_DATA_W-1:0] prdata
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("region request valid after reset");

    a_stalled_region_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable({i_out_first, i_out_last, i_out_fin}))
        else $error("stalled region request changed");

    a_region_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !$isunknown({i_out_first, i_out_last, i_out_fin}))
        else $error("region request carries unknown bits");

    a_threshold_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && psel && penable && pwrite &&
         (t_reg_sel'(paddr[APB_ADDR_W-1]) == REG_THRESHOLD))
        ##1 (t_reg_sel'(paddr[APB_ADDR_W-1]) == REG_THRESHOLD)
        |-> prdata[DATA_W-1:0] == $past(pwdata[DATA_W-1:0]))
        else $error("threshold register does not read back the written value");

endmodule

bind threshold_region_finder trf_checker u_trf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_region.valid),
    .i_out_ready (o_region.ready),
    .i_out_first (o_region.region_first),
    .i_out_last  (o_region.region_final),
    .i_out_fin   (o_region.final_region),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);
